/* src/uawp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uawp_pkg
// Operation codes and controller state encoding for the unit allocator.
// ----------------------------------------------------------------------------
package uawp_pkg;

    typedef enum logic [1:0] {
        FUNC_REQUEST  = 2'd0,
        FUNC_RELEASE  = 2'd1,
        FUNC_SET_WANT = 2'd2,
        FUNC_DEPOSIT  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    localparam int unsigned FIELD_REQ_W = 3;
    localparam int unsigned FIELD_TYPE_W = 3;
    localparam int unsigned FIELD_AMT_W = 8;
    localparam int unsigned CFG_W = 4;

endpackage

/* src/unit_allocator_with_preemption_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unit_allocator_with_preemption_unit
// Resource pool allocator with per-requester held and want counts and
// preemption of held units of every type in use on a denied request.
//
// Usage:
//   s_* channel carries one operation transaction (func, requester, rtype,
//   amount). m_* channel returns one result transaction per operation
//   (granted, preempted, stock_left, want_left, bad_item).
//   cfg_* channel writes types_in_use; write only while no operation is open.
//   Each operation first reads the requester's row of held and want counts
//   from the row memories as it is accepted in ST_IDLE, then in ST_EXEC
//   updates the row and the free pool and writes the row back. A new
//   operation is taken only when the last one has left ST_EXEC.
//   The result is registered; while the receiver stalls, the next operation
//   waits in the update cycle until the output register is free.
//   Reset (aresetn low, synchronous) empties the pool, marks every row as
//   all-zero through per-row valid bits and sets types_in_use to 8.
// ----------------------------------------------------------------------------
module unit_allocator_with_preemption_unit
    import uawp_pkg::*;
#(
    parameter int unsigned NUM_REQUESTERS = 8,
    parameter int unsigned NUM_TYPES = 8,
    parameter int unsigned COUNT_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_W-1:0]        cfg_types_in_use,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_func,
    input  logic [FIELD_REQ_W-1:0]  s_requester,
    input  logic [FIELD_TYPE_W-1:0] s_rtype,
    input  logic [FIELD_AMT_W-1:0]  s_amount,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_granted,
    output logic                    m_preempted,
    output logic [7:0]              m_stock_left,
    output logic [7:0]              m_want_left,
    output logic                    m_bad_item
);

    localparam int unsigned ADDR_W = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int unsigned TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int unsigned ROW_W = NUM_TYPES * COUNT_BITS;
    localparam int unsigned WIDE_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam int unsigned NT_W = 5;
    localparam int unsigned RQ_CMP_W = 7;

    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t CMAX = '1;

    function automatic count_t sat_add(input count_t a, input logic [WIDE_W-1:0] b);
        logic [WIDE_W:0] sum;
        sum = (WIDE_W + 1)'(a) + (WIDE_W + 1)'(b);
        return (sum > (WIDE_W + 1)'(CMAX)) ? CMAX : sum[COUNT_BITS-1:0];
    endfunction

    function automatic count_t sat_amt(input logic [FIELD_AMT_W-1:0] a);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(a);
        return (w > WIDE_W'(CMAX)) ? CMAX : w[COUNT_BITS-1:0];
    endfunction

    function automatic logic [7:0] to_out8(input count_t a);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(a);
        return w[7:0];
    endfunction

    // row memories, one row per requester
    logic [ROW_W-1:0] held_mem [NUM_REQUESTERS];
    logic [ROW_W-1:0] want_mem [NUM_REQUESTERS];
    logic [ROW_W-1:0] held_rd_reg;
    logic [ROW_W-1:0] want_rd_reg;

    logic [NUM_REQUESTERS-1:0] row_valid_reg;
    logic                      rd_valid_reg;

    count_t free_reg [NUM_TYPES];
    count_t free_next [NUM_TYPES];

    logic [CFG_W-1:0] types_in_use_reg;

    state_t state_reg, state_next;

    func_t                   func_reg;
    logic [FIELD_REQ_W-1:0]  req_reg;
    logic [FIELD_TYPE_W-1:0] ty_reg;
    logic [FIELD_AMT_W-1:0]  amt_reg;
    logic [ADDR_W-1:0]       row_addr_reg;

    logic       m_valid_reg, m_valid_next;
    logic       granted_reg, preempted_reg, bad_reg;
    logic [7:0] stock_reg, want_reg;

    logic                       s_fire;
    logic                       exec_done;
    logic                       s_rq_ok;
    logic [ADDR_W+FIELD_REQ_W-1:0] s_req_ext;
    logic [ADDR_W-1:0]          s_addr;

    logic [NT_W-1:0]            nt;
    logic                       ty_ok, rq_ok, bad;
    logic [TYPE_W+FIELD_TYPE_W-1:0] ty_ext;
    logic [TYPE_W-1:0]          ty_idx;
    logic [NUM_TYPES-1:0]       in_use;
    count_t                     held_row [NUM_TYPES];
    count_t                     want_row [NUM_TYPES];
    count_t                     held_nx [NUM_TYPES];
    count_t                     want_nx [NUM_TYPES];
    logic [ROW_W-1:0]           held_wr;
    logic [ROW_W-1:0]           want_wr;
    count_t                     free_ty;
    logic                       row_we;
    logic                       granted_c, preempted_c;
    logic [7:0]                 stock_c, want_c;

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire = s_valid && s_ready;
    assign exec_done = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    assign s_rq_ok = RQ_CMP_W'(s_requester) < RQ_CMP_W'(NUM_REQUESTERS);
    assign s_req_ext = (ADDR_W + FIELD_REQ_W)'(s_requester);
    assign s_addr = s_rq_ok ? s_req_ext[ADDR_W-1:0] : '0;

    assign m_valid = m_valid_reg;
    assign m_granted = granted_reg;
    assign m_preempted = preempted_reg;
    assign m_stock_left = stock_reg;
    assign m_want_left = want_reg;
    assign m_bad_item = bad_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // decode of the held operation
    always_comb begin
        nt = ({1'b0, types_in_use_reg} > NT_W'(NUM_TYPES)) ? NT_W'(NUM_TYPES)
                                                           : {1'b0, types_in_use_reg};
        ty_ok = NT_W'(ty_reg) < nt;
        rq_ok = RQ_CMP_W'(req_reg) < RQ_CMP_W'(NUM_REQUESTERS);
        case (func_reg)
            FUNC_DEPOSIT: bad = !ty_ok;
            FUNC_RELEASE: bad = !rq_ok;
            default:      bad = !ty_ok || !rq_ok;
        endcase
        ty_ext = (TYPE_W + FIELD_TYPE_W)'(ty_reg);
        ty_idx = ty_ok ? ty_ext[TYPE_W-1:0] : '0;
    end

    // row update
    always_comb begin
        for (int t = 0; t < NUM_TYPES; t++) begin
            held_row[t] = rd_valid_reg ? held_rd_reg[t*COUNT_BITS +: COUNT_BITS] : '0;
            want_row[t] = rd_valid_reg ? want_rd_reg[t*COUNT_BITS +: COUNT_BITS] : '0;
            in_use[t] = NT_W'(t) < nt;
            held_nx[t] = held_row[t];
            want_nx[t] = want_row[t];
            free_next[t] = free_reg[t];
        end
        free_ty = free_reg[ty_idx];
        granted_c = 1'b0;
        preempted_c = 1'b0;
        row_we = 1'b0;
        if (!bad) begin
            case (func_reg)
                FUNC_REQUEST: begin
                    row_we = 1'b1;
                    if (free_ty != '0) begin
                        free_next[ty_idx] = free_ty - count_t'(1);
                        if (want_row[ty_idx] != '0) begin
                            want_nx[ty_idx] = want_row[ty_idx] - count_t'(1);
                        end
                        held_nx[ty_idx] = sat_add(held_row[ty_idx], WIDE_W'(1));
                        granted_c = 1'b1;
                    end else begin
                        for (int t = 0; t < NUM_TYPES; t++) begin
                            if (in_use[t]) begin
                                free_next[t] = sat_add(free_reg[t], WIDE_W'(held_row[t]));
                                want_nx[t] = sat_add(want_row[t], WIDE_W'(held_row[t]));
                                held_nx[t] = '0;
                            end
                        end
                        preempted_c = 1'b1;
                    end
                end
                FUNC_RELEASE: begin
                    row_we = 1'b1;
                    for (int t = 0; t < NUM_TYPES; t++) begin
                        if (in_use[t]) begin
                            free_next[t] = sat_add(free_reg[t], WIDE_W'(held_row[t]));
                            held_nx[t] = '0;
                        end
                    end
                end
                FUNC_SET_WANT: begin
                    row_we = 1'b1;
                    want_nx[ty_idx] = sat_amt(amt_reg);
                    held_nx[ty_idx] = '0;
                end
                FUNC_DEPOSIT: begin
                    free_next[ty_idx] = sat_add(free_ty, WIDE_W'(amt_reg));
                end
                default: begin
                    row_we = 1'b0;
                end
            endcase
        end
        for (int t = 0; t < NUM_TYPES; t++) begin
            held_wr[t*COUNT_BITS +: COUNT_BITS] = held_nx[t];
            want_wr[t*COUNT_BITS +: COUNT_BITS] = want_nx[t];
        end
        stock_c = (!bad && ty_ok) ? to_out8(free_next[ty_idx]) : 8'd0;
        want_c = (!bad && ty_ok && rq_ok) ? to_out8(want_nx[ty_idx]) : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            held_rd_reg <= held_mem[s_addr];
            want_rd_reg <= want_mem[s_addr];
        end
        if (exec_done && row_we) begin
            held_mem[row_addr_reg] <= held_wr;
            want_mem[row_addr_reg] <= want_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg <= func_t'(s_func);
            req_reg <= s_requester;
            ty_reg <= s_rtype;
            amt_reg <= s_amount;
            row_addr_reg <= s_addr;
            rd_valid_reg <= row_valid_reg[s_addr];
        end
        if (exec_done) begin
            granted_reg <= granted_c;
            preempted_reg <= preempted_c;
            stock_reg <= stock_c;
            want_reg <= want_c;
            bad_reg <= bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            types_in_use_reg <= CFG_W'(8);
            row_valid_reg <= '0;
            for (int t = 0; t < NUM_TYPES; t++) begin
                free_reg[t] <= '0;
            end
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                types_in_use_reg <= cfg_types_in_use;
            end
            if (exec_done) begin
                for (int t = 0; t < NUM_TYPES; t++) begin
                    free_reg[t] <= free_next[t];
                end
                if (row_we) begin
                    row_valid_reg[row_addr_reg] <= 1'b1;
                end
            end
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the unit allocator with preemption. Named
// tests walk through grants, preemption on an empty pool, set want, release,
// deposit saturation and the types_in_use register. Random traffic then runs
// under several register settings. Every operation transaction is scored
// against an in-bench allocation model. The sender runs in random bursts and
// the receiver stalls on its own pattern, with one long output hold-off.
// ----------------------------------------------------------------------------
module testbench
    import uawp_pkg::*;
();

    localparam int N_REQ = 8;
    localparam int N_TYPES = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 80;

    typedef struct packed {
        func_t      func;
        logic [2:0] requester;
        logic [2:0] rtype;
        logic [7:0] amount;
    } alloc_op_t;

    typedef struct packed {
        logic       granted;
        logic       preempted;
        logic [7:0] stock_left;
        logic [7:0] want_left;
        logic       bad_item;
    } alloc_result_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_types_in_use;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_func;
    logic [2:0] s_requester;
    logic [2:0] s_rtype;
    logic [7:0] s_amount;
    logic       m_valid;
    logic       m_ready;
    logic       m_granted;
    logic       m_preempted;
    logic [7:0] m_stock_left;
    logic [7:0] m_want_left;
    logic       m_bad_item;

    logic [7:0] pool_free [N_TYPES];
    logic [7:0] req_held [N_REQ][N_TYPES];
    logic [7:0] req_want [N_REQ][N_TYPES];
    logic [3:0] types_cfg;

    alloc_result_t expected_results[$];
    alloc_result_t head_result;

    int mismatch_count = 0;
    int results_seen = 0;
    int ops_sent = 0;
    int grant_count = 0;
    int preempt_count = 0;
    int ignored_count = 0;
    int cycle_count = 0;
    int input_stall_cycles = 0;
    int burst_left = 0;
    int holdoff_request = 0;
    int holdoff_left = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    unit_allocator_with_preemption_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_types_in_use (cfg_types_in_use),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_requester      (s_requester),
        .s_rtype          (s_rtype),
        .s_amount         (s_amount),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_granted        (m_granted),
        .m_preempted      (m_preempted),
        .m_stock_left     (m_stock_left),
        .m_want_left      (m_want_left),
        .m_bad_item       (m_bad_item)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [7:0] add_sat(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

    function automatic int active_types();
        return (types_cfg > N_TYPES) ? N_TYPES : int'(types_cfg);
    endfunction

    function automatic alloc_result_t predict_allocation(input alloc_op_t op);
        alloc_result_t res;
        int active;
        logic type_ok;
        logic req_ok;
        logic bad;
        res = '0;
        active = active_types();
        type_ok = int'(op.rtype) < active;
        req_ok = int'(op.requester) < N_REQ;
        case (op.func)
            FUNC_DEPOSIT: bad = !type_ok;
            FUNC_RELEASE: bad = !req_ok;
            default: bad = !(type_ok && req_ok);
        endcase
        if (bad) begin
            res.bad_item = 1'b1;
            return res;
        end
        case (op.func)
            FUNC_REQUEST: begin
                if (pool_free[op.rtype] != 0) begin
                    pool_free[op.rtype] = pool_free[op.rtype] - 8'd1;
                    if (req_want[op.requester][op.rtype] != 0)
                        req_want[op.requester][op.rtype] = req_want[op.requester][op.rtype] - 8'd1;
                    req_held[op.requester][op.rtype] =
                        add_sat(req_held[op.requester][op.rtype], 8'd1);
                    res.granted = 1'b1;
                end else begin
                    for (int t = 0; t < active; t++) begin
                        pool_free[t] = add_sat(pool_free[t], req_held[op.requester][t]);
                        req_want[op.requester][t] =
                            add_sat(req_want[op.requester][t], req_held[op.requester][t]);
                        req_held[op.requester][t] = '0;
                    end
                    res.preempted = 1'b1;
                end
            end
            FUNC_RELEASE: begin
                for (int t = 0; t < active; t++) begin
                    pool_free[t] = add_sat(pool_free[t], req_held[op.requester][t]);
                    req_held[op.requester][t] = '0;
                end
            end
            FUNC_SET_WANT: begin
                req_want[op.requester][op.rtype] = op.amount;
                req_held[op.requester][op.rtype] = '0;
            end
            default: begin
                pool_free[op.rtype] = add_sat(pool_free[op.rtype], op.amount);
            end
        endcase
        if (type_ok) begin
            res.stock_left = pool_free[op.rtype];
            if (req_ok)
                res.want_left = req_want[op.requester][op.rtype];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int wanted);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     results_seen, field, got, wanted);
    endtask

    task automatic send_op(input func_t f, input int req, input int rt, input int amt);
        alloc_op_t op;
        alloc_result_t res;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        op.func = f;
        op.requester = req[2:0];
        op.rtype = rt[2:0];
        op.amount = amt[7:0];
        s_valid <= 1'b1;
        s_func <= op.func;
        s_requester <= op.requester;
        s_rtype <= op.rtype;
        s_amount <= op.amount;
        do @(posedge aclk); while (!s_ready);
        res = predict_allocation(op);
        grant_count += res.granted;
        preempt_count += res.preempted;
        ignored_count += res.bad_item;
        expected_results.push_back(res);
        ops_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_types_in_use(input int value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_types_in_use <= value[3:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        types_cfg = value[3:0];
    endtask

    task automatic send_random_op();
        int pick;
        int req;
        int rt;
        int amt;
        int active;
        active = active_types();
        pick = $urandom_range(0, 99);
        req = $urandom_range(0, N_REQ - 1);
        if (active == 0 || $urandom_range(0, 9) == 0)
            rt = $urandom_range(0, 7);
        else
            rt = $urandom_range(0, active - 1);
        if (pick < 45) begin
            send_op(FUNC_REQUEST, req, rt, $urandom_range(0, 255));
        end else if (pick < 55) begin
            send_op(FUNC_RELEASE, req, rt, $urandom_range(0, 255));
        end else if (pick < 70) begin
            amt = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
            send_op(FUNC_SET_WANT, req, rt, amt);
        end else begin
            amt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4);
            send_op(FUNC_DEPOSIT, req, rt, amt);
        end
    endtask

    task automatic test_empty_pool();
        send_op(FUNC_REQUEST, 0, 0, 0);
        send_op(FUNC_RELEASE, 7, 7, 8'hFF);
    endtask

    task automatic test_grant_and_preempt();
        send_op(FUNC_DEPOSIT, 0, 0, 3);
        send_op(FUNC_SET_WANT, 0, 0, 8'hFF);
        send_op(FUNC_REQUEST, 0, 0, 0);
        send_op(FUNC_REQUEST, 0, 0, 0);
        send_op(FUNC_REQUEST, 1, 0, 0);
        send_op(FUNC_REQUEST, 0, 0, 0);
    endtask

    task automatic test_set_want_and_release();
        send_op(FUNC_DEPOSIT, 3, 1, 2);
        send_op(FUNC_REQUEST, 1, 1, 0);
        send_op(FUNC_SET_WANT, 1, 1, 5);
        send_op(FUNC_REQUEST, 2, 1, 0);
        send_op(FUNC_RELEASE, 2, 1, 0);
    endtask

    task automatic test_saturation();
        send_op(FUNC_DEPOSIT, 0, 2, 8'hFF);
        send_op(FUNC_DEPOSIT, 0, 2, 8'h80);
        send_op(FUNC_REQUEST, 3, 2, 0);
        send_op(FUNC_DEPOSIT, 0, 2, 1);
        send_op(FUNC_REQUEST, 3, 5, 0);
    endtask

    task automatic test_types_in_use();
        write_types_in_use(3);
        send_op(FUNC_REQUEST, 0, 5, 0);
        send_op(FUNC_DEPOSIT, 0, 7, 9);
        send_op(FUNC_RELEASE, 4, 6, 0);
        send_op(FUNC_SET_WANT, 0, 3, 7);
        send_op(FUNC_SET_WANT, 0, 2, 7);
        write_types_in_use(0);
        send_op(FUNC_RELEASE, 0, 0, 0);
        send_op(FUNC_DEPOSIT, 0, 0, 1);
        write_types_in_use(15);
        send_op(FUNC_REQUEST, 6, 7, 0);
    endtask

    task automatic test_backpressure();
        holdoff_request = 300;
        repeat (30) send_random_op();
        drain_results();
    endtask

    task automatic test_random_traffic(input int types_setting);
        write_types_in_use(types_setting);
        repeat (RANDOM_PER_PHASE) send_random_op();
    endtask

    always @(posedge aclk) begin
        if (holdoff_request != 0) begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            rx_cycle++;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ((rx_cycle % 5) < 3);
                default: m_ready <= $urandom_range(0, 1);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", 1, 0);
            end else begin
                head_result = expected_results.pop_front();
                if (m_granted !== head_result.granted)
                    report_mismatch("granted", m_granted, head_result.granted);
                if (m_preempted !== head_result.preempted)
                    report_mismatch("preempted", m_preempted, head_result.preempted);
                if (m_stock_left !== head_result.stock_left)
                    report_mismatch("stock_left", m_stock_left, head_result.stock_left);
                if (m_want_left !== head_result.want_left)
                    report_mismatch("want_left", m_want_left, head_result.want_left);
                if (m_bad_item !== head_result.bad_item)
                    report_mismatch("bad_item", m_bad_item, head_result.bad_item);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (s_valid && !s_ready)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("unit_allocator_with_preemption_unit regression: fail");
            $finish;
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_types_in_use <= 4'd8;
        s_valid <= 1'b0;
        s_func <= FUNC_REQUEST;
        s_requester <= '0;
        s_rtype <= '0;
        s_amount <= '0;
        types_cfg = 4'd8;
        foreach (pool_free[t]) pool_free[t] = '0;
        foreach (req_held[r, t]) begin
            req_held[r][t] = '0;
            req_want[r][t] = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_pool();
        test_grant_and_preempt();
        test_set_want_and_release();
        test_saturation();
        test_types_in_use();
        test_random_traffic(8);
        test_random_traffic(5);
        test_backpressure();
        test_random_traffic(1);
        test_random_traffic(15);
        test_random_traffic(2);
        test_random_traffic(8);

        drain_results();
        repeat (8) @(posedge aclk);
        $display("covered %0d transactions: %0d grants, %0d preemptions, %0d ignored items",
                 ops_sent, grant_count, preempt_count, ignored_count);
        $display("types_in_use 0/1/2/3/5/8/15, %0d input stall cycles, %0d mismatches",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("unit_allocator_with_preemption_unit regression: pass");
        end else begin
            $display("unit_allocator_with_preemption_unit regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
src/uawp_pkg.sv
src/unit_allocator_with_preemption_unit.sv
bench/testbench.sv
